[src/flp_pkg.sv]
// ----------------------------------------------------------------------------
// flp_pkg
// Shared widths, constants, codes and helpers for the four-pole ladder filter.
// ----------------------------------------------------------------------------
package flp_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int FRAC_BITS       = SAMPLE_WIDTH - 4;
    localparam int COEF_SHIFT      = 16;
    localparam int MUL_WIDTH       = SAMPLE_WIDTH + 4;
    localparam int PROD_WIDTH      = 2 * MUL_WIDTH;
    localparam int TDATA_WIDTH     = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // soft clip intermediate widths: |y| < 5.0, y^2 < 25.0, y^3 < 125.0, y^3/6 < 21.0
    localparam int MAG_WIDTH       = FRAC_BITS + 3;
    localparam int SQ_WIDTH        = FRAC_BITS + 5;
    localparam int CUBE_WIDTH      = FRAC_BITS + 7;
    localparam int TERM_WIDTH      = FRAC_BITS + 5;
    localparam int DIV_SHIFT       = FRAC_BITS + 9;
    localparam longint unsigned DIV6_MUL = ((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6;

    localparam int NUM_STAGES      = 4;
    localparam int STAGE_WIDTH     = $clog2(NUM_STAGES);
    localparam logic [STAGE_WIDTH-1:0] LAST_STAGE = STAGE_WIDTH'(NUM_STAGES - 1);

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 18;
    localparam int P_WIDTH         = 17;
    localparam int K_WIDTH         = 18;
    localparam int R_WIDTH         = 18;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLE_GAIN      = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLE_FEEDBACK  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESONANCE_GAIN = 2'd2;

    localparam logic [P_WIDTH-1:0]        POLE_GAIN_RESET      = 17'd8192;
    localparam logic signed [K_WIDTH-1:0] POLE_FEEDBACK_RESET  = -18'sd54000;
    localparam logic [R_WIDTH-1:0]        RESONANCE_GAIN_RESET = 18'd0;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;

    localparam sample_t SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] CLIP_LIMIT = SAMPLE_WIDTH'(5) << FRAC_BITS;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_RES,
        OP_FORM_X,
        OP_MUL_P,
        OP_MUL_K,
        OP_STAGE,
        OP_CHECK,
        OP_MUL_SQ,
        OP_MUL_CUBE,
        OP_MUL_DIV,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MRES,
        S_FORMX,
        S_MP,
        S_MK,
        S_ST,
        S_CHK,
        S_SQ,
        S_CU,
        S_DV,
        S_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t                    op;
        logic [STAGE_WIDTH-1:0] stage;
        logic                   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clip_big;
    } dp_status_t;

    function automatic sample_t sat(input prod_t v);
        sample_t r;
        if (v > prod_t'(SMAX))
            r = SMAX;
        else if (v < prod_t'(SMIN))
            r = SMIN;
        else
            r = v[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

endpackage

[src/flp_datapath.sv]
// ----------------------------------------------------------------------------
// flp_datapath
// Coefficient registers, ladder state and one shared signed multiplier.
// ----------------------------------------------------------------------------
module flp_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [flp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [flp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  flp_pkg::sample_t                     sample_in,
    input  flp_pkg::dp_cmd_t                     cmd,
    output flp_pkg::dp_status_t                  status,
    output flp_pkg::sample_t                     sample_out
);
    import flp_pkg::*;

    logic [P_WIDTH-1:0]        pole_gain_reg;
    logic signed [K_WIDTH-1:0] pole_feedback_reg;
    logic [R_WIDTH-1:0]        resonance_gain_reg;

    sample_t stage_out_reg [NUM_STAGES];
    sample_t stage_in_delay_reg [NUM_STAGES];
    sample_t sample_reg;
    sample_t a_reg;
    sample_t out_reg;
    prod_t   acc_reg;
    prod_t   prod_reg;

    logic signed [SAMPLE_WIDTH:0]   sum;
    logic signed [MUL_WIDTH-1:0]    mul_a;
    logic signed [MUL_WIDTH-1:0]    mul_b;
    prod_t                          mul_p;
    sample_t                        y;
    logic                           neg;
    logic [SAMPLE_WIDTH-1:0]        mag;
    logic [MAG_WIDTH-1:0]           mag_s;
    logic [TERM_WIDTH-1:0]          term;
    prod_t                          x_wide;
    prod_t                          stage_diff;
    prod_t                          clip_wide;
    sample_t                        x_new;
    sample_t                        stage_new;
    sample_t                        clip_new;
    logic                           is_mul;

    assign sum   = (SAMPLE_WIDTH + 1)'(a_reg)
                 + (SAMPLE_WIDTH + 1)'(stage_in_delay_reg[cmd.stage]);
    assign y     = stage_out_reg[LAST_STAGE];
    assign neg   = y[SAMPLE_WIDTH-1];
    assign mag   = neg ? $unsigned(-y) : $unsigned(y);
    assign mag_s = mag[MAG_WIDTH-1:0];
    assign status.clip_big = (mag >= CLIP_LIMIT);

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        is_mul = 1'b1;
        unique case (cmd.op)
            OP_MUL_RES:
            begin
                mul_a = MUL_WIDTH'(stage_out_reg[LAST_STAGE]);
                mul_b = $signed({{(MUL_WIDTH-R_WIDTH){1'b0}}, resonance_gain_reg});
            end
            OP_MUL_P:
            begin
                mul_a = MUL_WIDTH'(sum);
                mul_b = $signed({{(MUL_WIDTH-P_WIDTH){1'b0}}, pole_gain_reg});
            end
            OP_MUL_K:
            begin
                mul_a = MUL_WIDTH'(stage_out_reg[cmd.stage]);
                mul_b = MUL_WIDTH'(pole_feedback_reg);
            end
            OP_MUL_SQ:
            begin
                mul_a = $signed({{(MUL_WIDTH-MAG_WIDTH){1'b0}}, mag_s});
                mul_b = $signed({{(MUL_WIDTH-MAG_WIDTH){1'b0}}, mag_s});
            end
            OP_MUL_CUBE:
            begin
                mul_a = $signed({{(MUL_WIDTH-SQ_WIDTH){1'b0}},
                                 prod_reg[FRAC_BITS +: SQ_WIDTH]});
                mul_b = $signed({{(MUL_WIDTH-MAG_WIDTH){1'b0}}, mag_s});
            end
            OP_MUL_DIV:
            begin
                // floor(c / 6) as c * ceil(2^DIV_SHIFT / 6) >> DIV_SHIFT, exact for c < 125.0
                mul_a = $signed({{(MUL_WIDTH-CUBE_WIDTH){1'b0}},
                                 prod_reg[FRAC_BITS +: CUBE_WIDTH]});
                mul_b = $signed(MUL_WIDTH'(DIV6_MUL));
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign x_wide     = prod_t'(sample_reg) - (prod_reg >>> COEF_SHIFT);
    assign x_new      = sat(x_wide);
    assign stage_diff = acc_reg - prod_reg;
    assign stage_new  = sat(stage_diff >>> COEF_SHIFT);
    assign term       = prod_reg[DIV_SHIFT +: TERM_WIDTH];
    assign clip_wide  = neg ? (prod_t'(y) + prod_t'(term)) : (prod_t'(y) - prod_t'(term));
    assign clip_new   = sat(clip_wide);
    assign sample_out = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_gain_reg      <= POLE_GAIN_RESET;
            pole_feedback_reg  <= POLE_FEEDBACK_RESET;
            resonance_gain_reg <= RESONANCE_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_POLE_GAIN)
                pole_gain_reg <= cfg_data[P_WIDTH-1:0];
            else if (cfg_index == CFG_POLE_FEEDBACK)
                pole_feedback_reg <= $signed(cfg_data[K_WIDTH-1:0]);
            else if (cfg_index == CFG_RESONANCE_GAIN)
                resonance_gain_reg <= cfg_data[R_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                stage_out_reg[i]      <= '0;
                stage_in_delay_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_STAGE)
            begin
                stage_out_reg[cmd.stage]      <= stage_new;
                stage_in_delay_reg[cmd.stage] <= a_reg;
            end
            else if (cmd.op == OP_CHECK && status.clip_big)
                stage_out_reg[LAST_STAGE] <= neg ? SMAX : SMIN;
            else if (cmd.op == OP_FINISH)
                stage_out_reg[LAST_STAGE] <= clip_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            sample_reg <= sample_in;
        if (cmd.op == OP_FORM_X)
            a_reg <= x_new;
        else if (cmd.op == OP_STAGE)
            a_reg <= stage_new;
        if (cmd.op == OP_MUL_K)
            acc_reg <= prod_reg;
        if (is_mul)
            prod_reg <= mul_p;
        if (cmd.emit)
            out_reg <= stage_out_reg[LAST_STAGE];
    end

endmodule

[src/flp_ctrl.sv]
// ----------------------------------------------------------------------------
// flp_ctrl
// Sequencer: stream handshakes and the per-sample multiply schedule.
// ----------------------------------------------------------------------------
module flp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  flp_pkg::dp_status_t  status,
    output flp_pkg::dp_cmd_t     cmd
);
    import flp_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [STAGE_WIDTH-1:0] stage_reg;
    logic [STAGE_WIDTH-1:0] stage_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        cmd.op     = OP_NONE;
        cmd.stage  = stage_reg;
        cmd.emit   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MRES;
                end
            end
            S_MRES:
            begin
                cmd.op     = OP_MUL_RES;
                state_next = S_FORMX;
            end
            S_FORMX:
            begin
                cmd.op     = OP_FORM_X;
                stage_next = '0;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.op     = OP_MUL_P;
                state_next = S_MK;
            end
            S_MK:
            begin
                cmd.op     = OP_MUL_K;
                state_next = S_ST;
            end
            S_ST:
            begin
                cmd.op = OP_STAGE;
                if (stage_reg == LAST_STAGE)
                    state_next = S_CHK;
                else
                begin
                    stage_next = stage_reg + STAGE_WIDTH'(1);
                    state_next = S_MP;
                end
            end
            S_CHK:
            begin
                cmd.op     = OP_CHECK;
                state_next = status.clip_big ? S_EMIT : S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_CU;
            end
            S_CU:
            begin
                cmd.op     = OP_MUL_CUBE;
                state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op     = OP_MUL_DIV;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MRES))
        else $error("accepted transfer did not start the schedule");

    a_last_stage_to_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ST && stage_reg == LAST_STAGE) |=> (state_reg == S_CHK))
        else $error("ladder did not end after the last stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over a pending transfer");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("emitted result not presented");
`endif

endmodule

[src/four_pole_ladder_lowpass.sv]
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass
// Resonant four-stage ladder low-pass with cubic soft clip, fixed point.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata[23:0] sample_in
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata[23:0] sample_out
//   cfg       in   cfg_we                        cfg_index, cfg_data
//
// Each sample is worked through the single shared multiplier as up to 12 products
// in sequence, fewer when the soft clip saturates.
// A new sample is accepted only while the sequencer is idle; a finished
// result waits in the output register without blocking the next accept.
// Reset clears all stage state and loads the coefficient defaults.
// ----------------------------------------------------------------------------
module four_pole_ladder_lowpass (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [flp_pkg::TDATA_WIDTH-1:0]      s_axis_tdata,   // sample_in
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [flp_pkg::TDATA_WIDTH-1:0]      m_axis_tdata,   // sample_out
    input  logic                                 cfg_we,
    input  logic [flp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [flp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import flp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    sample_t    sample_in;
    sample_t    sample_out;

    assign sample_in    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign m_axis_tdata = TDATA_WIDTH'($unsigned(sample_out));

    flp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    flp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out)
    );

endmodule
